[hdl/jpte_pkg.sv]
// jpte_pkg: shared types and constants for the joint pose text encoder
// depends on nothing; imported by jpte_comp_code and joint_pose_text_encoder_core
`timescale 1ns / 1ps
package jpte_pkg;

  // field widths
  localparam int COMP_W   = 20;
  localparam int JOINT_W  = 9;
  localparam int CODE_W   = 13;
  localparam int CHAR_W   = 7;
  localparam int NUM_COMP = 9;

  // default fraction bits of the components
  localparam int FRAC_BITS_DEF = 16;

  // value code range: two base-80 digits
  localparam logic [CODE_W-1:0] CODE_MAX   = 13'd6399;
  localparam logic [CODE_W-1:0] HDR_SAT    = 13'd3199;
  localparam logic [CODE_W-1:0] HDR_OFFSET = 13'd3200;
  localparam int                CLAMP_LO   = -3200;
  localparam int                CLAMP_HI   = 3199;
  localparam int                COMP_OFFSET = 3200;

  // characters
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'd46;
  localparam logic [CHAR_W-1:0] ZERO_MARK  = 7'd37;
  localparam logic [CHAR_W-1:0] RADIX      = 7'd80;

  // divide by 80: floor(n * 3277 / 2^18) is exact for n below 6400
  localparam int DIV80_MUL   = 3277;
  localparam int DIV80_SHIFT = 18;
  localparam int DIV80_PW    = 25;

  // value index within one record
  typedef logic [3:0] vidx_t;
  localparam vidx_t VI_HEADER     = 4'd0;
  localparam vidx_t VI_ROT_FIRST  = 4'd1;
  localparam vidx_t VI_ROT_LAST   = 4'd3;
  localparam vidx_t VI_POS_LAST   = 4'd6;
  localparam vidx_t VI_SCALE_LAST = 4'd9;
  localparam vidx_t VI_MARK       = 4'd10;

  typedef logic [CODE_W-1:0] code_t;

endpackage

[hdl/joint_pose_text_encoder_core.sv]
// joint_pose_text_encoder_core: turns one joint record into a stream of text characters
// depends on jpte_pkg and jpte_comp_code
// a record's first character passes the hold, code and output registers after acceptance
// throughput: one character per cycle unless out_ready stalls the output; a record is 3, 8,
// 14 or 20 characters long; the next record is taken as the last value issues
// reset: rst_n clears the valid flags of the hold, code and output stages only
`timescale 1ns / 1ps
module joint_pose_text_encoder_core #(
  parameter int FRAC_BITS = jpte_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [jpte_pkg::JOINT_W-1:0]        in_joint_number,
  input  logic                                in_mirrored,
  input  logic                                in_base_rotation_zero,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_rot_x,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_rot_y,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_rot_z,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_pos_x,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_pos_y,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_pos_z,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_scale_x,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_scale_y,
  input  logic signed [jpte_pkg::COMP_W-1:0]  in_scale_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [jpte_pkg::CHAR_W-1:0]         out_char_code,
  output logic                                out_last_char
);
  import jpte_pkg::*;

  // hold stage: the accepted record and the value being issued
  logic                     hold_valid_r;
  logic [JOINT_W-1:0]       hold_joint_r;
  logic                     hold_mir_r;
  logic                     hold_bz_r;
  logic signed [COMP_W-1:0] hold_comp_r [NUM_COMP];
  vidx_t                    hold_vi_r;
  vidx_t                    hold_last_vi_r;

  // code stage: one value code, split into two characters, or the one mark character
  logic  code_valid_r;
  code_t code_r;
  logic  code_mark_r;
  logic  code_last_r;
  logic  code_phase_r;

  // output stage
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic in_accept;
  logic o_load;
  logic c_emit;
  logic c_done;
  logic h_issue;
  logic h_done;

  // handshake chain, back to front
  always_comb begin
    o_load    = !out_valid_r || out_ready;
    c_emit    = code_valid_r && o_load;
    c_done    = c_emit && (code_mark_r || code_phase_r);
    h_issue   = hold_valid_r && (!code_valid_r || c_done);
    h_done    = h_issue && (hold_vi_r == hold_last_vi_r);
    in_ready  = !hold_valid_r || h_done;
    in_accept = in_valid && in_ready;
  end

  // which values a record sends
  logic  rot_zero;
  logic  pos_zero;
  logic  sca_zero;
  vidx_t last_vi;

  always_comb begin
    rot_zero = (in_rot_x == '0) && (in_rot_y == '0) && (in_rot_z == '0);
    pos_zero = (in_pos_x == '0) && (in_pos_y == '0) && (in_pos_z == '0);
    sca_zero = (in_scale_x == '0) && (in_scale_y == '0) && (in_scale_z == '0);
    if (rot_zero && pos_zero && sca_zero) begin
      last_vi = VI_MARK;
    end else if (!sca_zero) begin
      last_vi = VI_SCALE_LAST;
    end else if (!pos_zero) begin
      last_vi = VI_POS_LAST;
    end else begin
      last_vi = VI_ROT_LAST;
    end
  end

  // next value index: the all-zero record jumps from header to the mark
  vidx_t hold_vi_nxt;

  always_comb begin
    if (hold_vi_r == VI_HEADER && hold_last_vi_r == VI_MARK) begin
      hold_vi_nxt = VI_MARK;
    end else begin
      hold_vi_nxt = hold_vi_r + vidx_t'(1);
    end
  end

  // hold stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_accept) begin
      hold_valid_r <= 1'b1;
    end else if (h_done) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_joint_r   <= in_joint_number;
      hold_mir_r     <= in_mirrored;
      hold_bz_r      <= in_base_rotation_zero;
      hold_comp_r[0] <= in_rot_x;
      hold_comp_r[1] <= in_rot_y;
      hold_comp_r[2] <= in_rot_z;
      hold_comp_r[3] <= in_pos_x;
      hold_comp_r[4] <= in_pos_y;
      hold_comp_r[5] <= in_pos_z;
      hold_comp_r[6] <= in_scale_x;
      hold_comp_r[7] <= in_scale_y;
      hold_comp_r[8] <= in_scale_z;
      hold_last_vi_r <= last_vi;
      hold_vi_r      <= VI_HEADER;
    end else if (h_issue) begin
      hold_vi_r <= hold_vi_nxt;
    end
  end

  // select the component for the current value index
  vidx_t                    comp_idx;
  logic signed [COMP_W-1:0] comp_sel;
  code_t                    comp_code;

  always_comb begin
    comp_idx = hold_vi_r - VI_ROT_FIRST;
    if (hold_vi_r >= VI_ROT_FIRST && hold_vi_r <= VI_SCALE_LAST) begin
      comp_sel = hold_comp_r[comp_idx];
    end else begin
      comp_sel = '0;
    end
  end

  jpte_comp_code #(
    .FRAC_BITS (FRAC_BITS)
  ) u_comp_code (
    .comp (comp_sel),
    .code (comp_code)
  );

  // header value: joint * 10 + mirrored + 2 * base zero, saturated, offset
  code_t hdr_raw;
  code_t hdr_code;
  code_t value_code;

  always_comb begin
    hdr_raw = (code_t'(hold_joint_r) << 3) + (code_t'(hold_joint_r) << 1)
            + code_t'(hold_mir_r) + (code_t'(hold_bz_r) << 1);
    if (hdr_raw > HDR_SAT) begin
      hdr_code = HDR_SAT + HDR_OFFSET;
    end else begin
      hdr_code = hdr_raw + HDR_OFFSET;
    end
    if (hold_vi_r == VI_HEADER) begin
      value_code = hdr_code;
    end else begin
      value_code = comp_code;
    end
  end

  // code stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_valid_r <= 1'b0;
    end else if (h_issue) begin
      code_valid_r <= 1'b1;
    end else if (c_done) begin
      code_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (h_issue) begin
      code_r       <= value_code;
      code_mark_r  <= (hold_vi_r == VI_MARK);
      code_last_r  <= (hold_vi_r == hold_last_vi_r);
      code_phase_r <= 1'b0;
    end else if (c_emit) begin
      code_phase_r <= 1'b1;
    end
  end

  // base-80 split and character select
  logic [DIV80_PW-1:0] div_prod;
  logic [CHAR_W-1:0]   digit_hi;
  code_t               hi_times;
  code_t               rem_wide;
  logic [CHAR_W-1:0]   digit_lo;
  logic [CHAR_W-1:0]   char_nxt;

  always_comb begin
    div_prod = DIV80_PW'(code_r) * DIV80_PW'(DIV80_MUL);
    digit_hi = CHAR_W'(div_prod >> DIV80_SHIFT);
    hi_times = code_t'(digit_hi) * code_t'(RADIX);
    rem_wide = code_r - hi_times;
    digit_lo = rem_wide[CHAR_W-1:0];
    if (code_mark_r) begin
      char_nxt = ZERO_MARK;
    end else if (code_phase_r) begin
      char_nxt = digit_lo + DIGIT_BASE;
    end else begin
      char_nxt = digit_hi + DIGIT_BASE;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_emit) begin
      out_char_r <= char_nxt;
      out_last_r <= code_last_r && (code_mark_r || code_phase_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule

[hdl/jpte_comp_code.sv]
// jpte_comp_code: scales one fixed point component by 1000, rounds, clamps, offsets
// depends on jpte_pkg
`timescale 1ns / 1ps
module jpte_comp_code #(
  parameter int FRAC_BITS = jpte_pkg::FRAC_BITS_DEF
) (
  input  logic signed [jpte_pkg::COMP_W-1:0] comp,
  output jpte_pkg::code_t                     code
);
  import jpte_pkg::*;

  localparam int PW = COMP_W + 11;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] LO   = PW'(CLAMP_LO);
  localparam logic signed [PW-1:0] HI   = PW'(CLAMP_HI);
  localparam logic signed [PW-1:0] OFS  = PW'(COMP_OFFSET);

  logic signed [PW-1:0] ext;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] q;
  logic signed [PW-1:0] biased;

  // times 1000 as 1024 - 16 - 8, then round half up
  always_comb begin
    ext    = PW'(comp);
    prod   = (ext <<< 10) - (ext <<< 4) - (ext <<< 3);
    rnd    = prod + HALF;
    q      = rnd >>> FRAC_BITS;
    biased = q + OFS;
  end

  // clamp and offset
  always_comb begin
    if (q < LO) begin
      code = '0;
    end else if (q > HI) begin
      code = CODE_MAX;
    end else begin
      code = biased[CODE_W-1:0];
    end
  end

endmodule

[verif/joint_pose_text_encoder_core_test.sv]
// joint_pose_text_encoder_core_test: self-checking testbench for the joint pose text encoder
// depends on jpte_pkg and joint_pose_text_encoder_core; predicts every character and checks
`timescale 1ns / 1ps
module joint_pose_text_encoder_core_test;
  import jpte_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 300;

  // character codes of the text format
  localparam logic [CHAR_W-1:0] CH_DIGIT0 = 7'd46;  // '.'
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'd37;  // '%'
  localparam int                CH_RADIX  = 80;

  // component order inside a record
  localparam int C_ROT_X = 0;
  localparam int C_POS_X = 3;
  localparam int C_SCL_X = 6;

  typedef struct packed {
    logic [JOINT_W-1:0]               joint;
    logic                             mir;
    logic                             bz;
    logic [NUM_COMP-1:0][COMP_W-1:0]  comp;
  } pose_rec_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [JOINT_W-1:0] in_joint_number = '0;
  logic in_mirrored = 1'b0;
  logic in_base_rotation_zero = 1'b0;
  logic signed [COMP_W-1:0] in_rot_x = '0, in_rot_y = '0, in_rot_z = '0;
  logic signed [COMP_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [COMP_W-1:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char_code;
  logic out_last_char;

  text_word_t pending_text[$];
  int errors = 0;
  int records_sent = 0;
  int words_checked = 0;
  int n_mark = 0, n_rot = 0, n_pos = 0, n_scale = 0;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int rx_hold = 0;

  joint_pose_text_encoder_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_joint_number(in_joint_number), .in_mirrored(in_mirrored),
    .in_base_rotation_zero(in_base_rotation_zero),
    .in_rot_x(in_rot_x), .in_rot_y(in_rot_y), .in_rot_z(in_rot_z),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y), .in_scale_z(in_scale_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_char_code(out_char_code), .out_last_char(out_last_char)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // component value code: round(v * 1000 / 2^FRAC) toward +inf at halves, clamp, offset
  function automatic int comp_value(logic [COMP_W-1:0] raw);
    longint v, t, q;
    v = longint'($signed(raw));
    t = v * 1000 + (longint'(1) <<< (FRAC - 1));
    q = t >>> FRAC;
    if (q < -3200) q = -3200;
    if (q > 3199) q = 3199;
    return int'(q) + 3200;
  endfunction

  // one value as two base-80 digit characters
  function automatic void put_digits(ref text_word_t w[$], input int n);
    w.insert(w.size(), text_word_t'{code: CH_DIGIT0 + 7'(n / CH_RADIX), last: 1'b0});
    w.insert(w.size(), text_word_t'{code: CH_DIGIT0 + 7'(n % CH_RADIX), last: 1'b0});
  endfunction

  // expected text of one record, appended to the pending characters
  function automatic void predict_text(pose_rec_t r);
    text_word_t words[$];
    int hdr;
    bit rot_z, pos_z, scl_z;
    hdr = int'(r.joint) * 10 + int'(r.mir) + 2 * int'(r.bz);
    if (hdr > 3199) hdr = 3199;
    put_digits(words, hdr + 3200);
    rot_z = r.comp[0] == '0 && r.comp[1] == '0 && r.comp[2] == '0;
    pos_z = r.comp[3] == '0 && r.comp[4] == '0 && r.comp[5] == '0;
    scl_z = r.comp[6] == '0 && r.comp[7] == '0 && r.comp[8] == '0;
    if (rot_z && pos_z && scl_z) begin
      words.insert(words.size(), text_word_t'{code: CH_ZERO, last: 1'b0});
    end else begin
      for (int i = C_ROT_X; i < C_POS_X; i++) put_digits(words, comp_value(r.comp[i]));
      if (!pos_z || !scl_z)
        for (int i = C_POS_X; i < C_SCL_X; i++) put_digits(words, comp_value(r.comp[i]));
      if (!scl_z)
        for (int i = C_SCL_X; i < NUM_COMP; i++) put_digits(words, comp_value(r.comp[i]));
    end
    words[words.size() - 1].last = 1'b1;
    case (words.size())
      3: n_mark++;
      8: n_rot++;
      14: n_pos++;
      default: n_scale++;
    endcase
    foreach (words[i]) pending_text.insert(pending_text.size(), words[i]);
  endfunction

  // offer one record after a random gap (none in a burst), then wait for the handshake
  task automatic send_record(pose_rec_t r);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_joint_number <= r.joint;
    in_mirrored <= r.mir;
    in_base_rotation_zero <= r.bz;
    in_rot_x <= r.comp[0];
    in_rot_y <= r.comp[1];
    in_rot_z <= r.comp[2];
    in_pos_x <= r.comp[3];
    in_pos_y <= r.comp[4];
    in_pos_z <= r.comp[5];
    in_scale_x <= r.comp[6];
    in_scale_y <= r.comp[7];
    in_scale_z <= r.comp[8];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_text(r);
    records_sent++;
  endtask

  function automatic pose_rec_t mk_rec(int j, bit m, bit b, int rx, int ry, int rz,
                                        int px, int py, int pz, int sx, int sy, int sz);
    pose_rec_t r;
    r.joint = JOINT_W'(j);
    r.mir = m;
    r.bz = b;
    r.comp[0] = COMP_W'(rx);
    r.comp[1] = COMP_W'(ry);
    r.comp[2] = COMP_W'(rz);
    r.comp[3] = COMP_W'(px);
    r.comp[4] = COMP_W'(py);
    r.comp[5] = COMP_W'(pz);
    r.comp[6] = COMP_W'(sx);
    r.comp[7] = COMP_W'(sy);
    r.comp[8] = COMP_W'(sz);
    return r;
  endfunction

  // one random component: full range, small, exact halves, near the clamp, zero
  function automatic logic [COMP_W-1:0] rand_comp();
    int mag;
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return COMP_W'($urandom);
      3: mag = $urandom_range(0, 300);
      4: mag = 4096 * (2 * $urandom_range(0, 50) + 1);
      5: mag = $urandom_range(209600, 209800);
      default: mag = $urandom_range(0, 215000);
    endcase
    return $urandom_range(0, 1) ? COMP_W'(-mag) : COMP_W'(mag);
  endfunction

  // random record of a given text length class: 0 marker, 1 rotation, 2 position, 3 scale
  function automatic pose_rec_t rand_rec(int shape);
    pose_rec_t r;
    r.joint = ($urandom_range(0, 7) == 0) ? JOINT_W'($urandom_range(320, 511))
                                          : JOINT_W'($urandom_range(0, 319));
    r.mir = 1'($urandom);
    r.bz = 1'($urandom);
    for (int i = 0; i < NUM_COMP; i++) begin
      if ((i >= C_POS_X && shape < 2) || (i >= C_SCL_X && shape < 3) || shape == 0)
        r.comp[i] = '0;
      else
        r.comp[i] = rand_comp();
    end
    return r;
  endfunction

  // extremes, saturated header, each text length, halves and clamp edges
  task automatic test_directed();
    send_record(mk_rec(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_record(mk_rec(511, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_record(mk_rec(320, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_record(mk_rec(319, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_record(mk_rec(1, 1, 0, 524287, -524288, 1, 0, 0, 0, 0, 0, 0));
    send_record(mk_rec(2, 0, 1, 0, 0, 0, -1, 1, 0, 0, 0, 0));
    send_record(mk_rec(3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1));
    send_record(mk_rec(4, 1, 1, 524287, 524287, 524287, -524288, -524288, -524288,
                       524287, -524288, 524287));
    send_record(mk_rec(5, 0, 0, 4096, -4096, 12288, -12288, 0, 0, 0, 0, 0));
    send_record(mk_rec(6, 0, 0, 209683, 209684, -209748, -209749, 0, 0, 0, 0, 0));
    send_record(mk_rec(7, 1, 0, 0, 1, 0, 0, 0, 0, 65536, -65536, 32768));
    send_record(mk_rec(8, 0, 1, -1, -32, 33, 32767, -32769, 100000, 0, 0, 0));
    send_record(mk_rec(255, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_record(mk_rec(256, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    send_record(mk_rec(100, 0, 0, -209749, 209684, 4096, 0, 0, 0, -4096, 0, 0));
    send_record(mk_rec(319, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // back to back on both sides
  task automatic test_streaming();
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (30) send_record(rand_rec($urandom_range(0, 3)));
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // receiver holds off while records keep coming, so the input stalls
  task automatic test_backpressure();
    tx_burst = 1'b1;
    rx_hold = HOLD_CYCLES;
    repeat (12) send_record(rand_rec(3));
    tx_burst = 1'b0;
  endtask

  // random records, half of them with full text
  task automatic test_random();
    int shape;
    repeat (170) begin
      case ($urandom_range(0, 9))
        0: shape = 0;
        1, 2: shape = 1;
        3, 4: shape = 2;
        default: shape = 3;
      endcase
      send_record(rand_rec(shape));
    end
  endtask

  // receiver: random stall before each word outside a burst, one long hold when asked
  initial begin
    int n;
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = rx_burst ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // check every accepted word against the oldest pending character
  always @(posedge clk) begin
    text_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (pending_text.size() == 0) begin
        $error("unexpected word: char_code %0d last_char %0d", out_char_code, out_last_char);
        errors++;
      end else begin
        exp_w = pending_text[0];
        pending_text.delete(0);
        if (out_char_code !== exp_w.code) begin
          $error("char_code: expected %0d, got %0d", exp_w.code, out_char_code);
          errors++;
        end
        if (out_last_char !== exp_w.last) begin
          $error("last_char: expected %0d, got %0d", exp_w.last, out_last_char);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("joint_pose_text_encoder_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_streaming();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_text.size() != 0) begin
      $error("%0d characters never arrived", pending_text.size());
      errors++;
    end
    $display("covered %0d records and %0d characters under random and long stalls",
             records_sent, words_checked);
    $display("text lengths: %0d marker, %0d rotation, %0d position, %0d scale",
             n_mark, n_rot, n_pos, n_scale);
    if (errors == 0) begin
      $display("joint_pose_text_encoder_core regression: pass");
    end else begin
      $display("joint_pose_text_encoder_core regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/jpte_pkg.sv
hdl/jpte_comp_code.sv
hdl/joint_pose_text_encoder_core.sv
verif/joint_pose_text_encoder_core_test.sv
